>>> rtl/tcs_pkg.sv
// Shared types, codes and constants of the timed command scheduler.
package tcs_pkg;

  // Default build sizes for the top level.
  localparam int DEFAULT_QUEUE_DEPTH  = 256;
  localparam int DEFAULT_PAYLOAD_BITS = 32;

  // Substitutes for register values of zero.
  localparam logic [8:0]  DEFAULT_CAPACITY = 9'd200;
  localparam logic [15:0] MIN_LAG          = 16'd1;

  // Register values after reset.
  localparam logic [8:0]  RESET_CAPACITY = 9'd200;
  localparam logic [15:0] RESET_TIMEOUT  = 16'd200;
  localparam logic [15:0] RESET_LAG      = 16'd1;

  // Configuration port.
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAG      = 2'd2;

  // Event codes.
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_PACKET = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Signed width for time sums; wide enough that nothing wraps.
  localparam int TIME_W = 35;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [31:0] command_payload;
    logic [15:0] duration_ms;
  } cmd_t;

  typedef struct packed {
    logic        push_accepted;
    logic        overflow;
    logic        connected;
    logic        active_valid;
    logic [31:0] active_payload;
    logic [15:0] active_duration_ms;
    logic [32:0] active_start_ms;
    logic [8:0]  queue_count;
    logic [8:0]  skipped_count;
  } rsp_t;

  // Effective configuration, with zero substitutes already applied.
  typedef struct packed {
    logic [8:0]  capacity;
    logic [15:0] timeout_ms;
    logic [15:0] lag_ms;
  } cfg_t;

endpackage

>>> rtl/tcs_cfg_regs.sv
// Configuration registers and their effective values.
module tcs_cfg_regs #(
  parameter int QUEUE_DEPTH = tcs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tcs_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output tcs_pkg::cfg_t                  cfg
);

  localparam int DEPTH_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W   = (DEPTH_W > 9) ? DEPTH_W : 9;

  logic [8:0]  queue_capacity;
  logic [15:0] connection_timeout_ms;
  logic [15:0] max_lag_ms;

  logic [8:0]       cap_raw;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] depth_ext;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity        <= tcs_pkg::RESET_CAPACITY;
      connection_timeout_ms <= tcs_pkg::RESET_TIMEOUT;
      max_lag_ms            <= tcs_pkg::RESET_LAG;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcs_pkg::REG_CAPACITY: queue_capacity        <= cfg_data[8:0];
        tcs_pkg::REG_TIMEOUT:  connection_timeout_ms <= cfg_data;
        tcs_pkg::REG_LAG:      max_lag_ms            <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero capacity means the default; any capacity is held to the built depth.
  always_comb begin
    cap_raw   = (queue_capacity == 9'd0) ? tcs_pkg::DEFAULT_CAPACITY : queue_capacity;
    cap_ext   = CMP_W'(cap_raw);
    depth_ext = CMP_W'(QUEUE_DEPTH);
    cfg.capacity   = (cap_ext > depth_ext) ? 9'(depth_ext) : cap_raw;
    cfg.timeout_ms = connection_timeout_ms;
    cfg.lag_ms     = (max_lag_ms == 16'd0) ? tcs_pkg::MIN_LAG : max_lag_ms;
  end

endmodule

>>> rtl/tcs_watchdog.sv
// Link watchdog: last packet time and the connected test.
module tcs_watchdog (
  input  logic        clk,
  input  logic        rst,
  input  logic        packet,
  input  logic [31:0] now_ms,
  input  logic [15:0] timeout_ms,
  output logic        link_up
);

  logic        packet_seen;
  logic [31:0] last_packet_time;

  logic signed [33:0] gap;

  // Note each received packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_seen      <= 1'b0;
      last_packet_time <= 32'd0;
    end else if (packet) begin
      packet_seen      <= 1'b1;
      last_packet_time <= now_ms;
    end
  end

  // A negative gap (time going backwards) still counts as connected.
  always_comb begin
    gap     = $signed({2'b00, now_ms}) - $signed({2'b00, last_packet_time});
    link_up = packet_seen && (gap <= $signed({18'd0, timeout_ms}));
  end

endmodule

>>> rtl/timed_command_scheduler.sv
// Top level: event sequencer, slot memory, queue pointers and active command.
// Push, packet and clear: the beat is taken in S_IDLE, executed in S_EXEC, and the result
// is registered from S_EMIT. A tick that promotes goes on to S_PROM (straight to S_EMIT from
// an empty queue) and walks k queued entries through S_PROM and S_EVAL (a slot read and a check each).
// One event is in work at a time; the next beat is taken once the result is registered.
// Reset is synchronous; the slot memory is not cleared and needs no clearing pass.
module timed_command_scheduler #(
  parameter int QUEUE_DEPTH  = tcs_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = tcs_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  tcs_pkg::cmd_t                  cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output tcs_pkg::rsp_t                  rsp,
  input  logic                           cfg_write,
  input  logic [tcs_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W       = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
  localparam int STORE_PAY_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int SLOT_W      = STORE_PAY_W + 16;
  localparam int TW          = tcs_pkg::TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PROM = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;

  tcs_pkg::cmd_t item;
  tcs_pkg::cfg_t cfg;
  tcs_pkg::rsp_t rsp_next;
  logic          link_up;

  // Queue and active command.
  logic [IDX_W-1:0]       head_index;
  logic [IDX_W-1:0]       tail_index;
  logic [CNT_W-1:0]       entry_count;
  logic                   active_flag;
  logic [STORE_PAY_W-1:0] active_pay;
  logic [15:0]            active_dur;
  logic [32:0]            active_start;
  logic [32:0]            time_cursor;
  logic                   cursor_valid;

  // Per-event result flags.
  logic       accepted;
  logic       ovf;
  logic [8:0] skipped;

  // Slot memory.
  logic [SLOT_W-1:0] slot_mem [QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot_rdata;
  logic              mem_we;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_wdata;

  logic                   full;
  logic                   packet_note;
  logic                   expired;
  logic                   skip_entry;
  logic                   late;
  logic [15:0]            rd_dur;
  logic [STORE_PAY_W-1:0] rd_pay;
  logic [32:0]            cursor_eff;
  logic [32:0]            now_ext;

  logic signed [TW-1:0] now_s;
  logic signed [TW-1:0] cursor_s;
  logic signed [TW-1:0] start_s;
  logic signed [TW-1:0] act_dur_s;
  logic signed [TW-1:0] rd_dur_s;
  logic signed [TW-1:0] floor_s;
  logic signed [TW-1:0] end_s;
  logic signed [TW-1:0] late_end_s;
  logic signed [TW-1:0] expire_end_s;

  // Ring index advance; an advanced index at or past the capacity wraps to zero.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [8:0]       cap);
    logic [CMP_W-1:0] nxt;
    nxt = CMP_W'(idx) + CMP_W'(1);
    return (nxt >= CMP_W'(cap)) ? '0 : IDX_W'(nxt);
  endfunction

  tcs_cfg_regs #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcs_watchdog u_watchdog (
    .clk        (clk),
    .rst        (rst),
    .packet     (packet_note),
    .now_ms     (item.now_ms),
    .timeout_ms (cfg.timeout_ms),
    .link_up    (link_up)
  );

  assign cmd_ready = (state == S_IDLE);

  // Time arithmetic, all in a signed width that cannot wrap.
  always_comb begin
    now_ext      = {1'b0, item.now_ms};
    now_s        = $signed({{(TW-32){1'b0}}, item.now_ms});
    cursor_s     = $signed({{(TW-33){1'b0}}, time_cursor});
    start_s      = $signed({{(TW-33){1'b0}}, active_start});
    act_dur_s    = $signed({{(TW-16){1'b0}}, active_dur});
    rd_dur       = slot_rdata[15:0];
    rd_pay       = slot_rdata[SLOT_W-1:16];
    rd_dur_s     = $signed({{(TW-16){1'b0}}, rd_dur});
    floor_s      = now_s - $signed({{(TW-16){1'b0}}, cfg.lag_ms});
    end_s        = cursor_s + rd_dur_s;
    late_end_s   = floor_s + rd_dur_s;
    expire_end_s = start_s + act_dur_s;
    expired      = active_flag && ((now_s - start_s) >= act_dur_s);
    skip_entry   = (end_s <= floor_s);
    late         = (cursor_s < floor_s);
    cursor_eff   = cursor_valid ? time_cursor : now_ext;
    full         = CMP_W'(entry_count) >= CMP_W'(cfg.capacity);
  end

  // Memory controls.
  always_comb begin
    packet_note = (state == S_EXEC) && (item.func == tcs_pkg::FUNC_PACKET);
    mem_we      = (state == S_EXEC) && (item.func == tcs_pkg::FUNC_PUSH) && !full;
    mem_re      = (state == S_PROM) && (entry_count != '0);
    mem_wdata   = {STORE_PAY_W'(item.command_payload), item.duration_ms};
  end

  // Slot memory, one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[tail_index] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      slot_rdata <= slot_mem[head_index];
    end
  end

  // Event sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_index   <= '0;
      tail_index   <= '0;
      entry_count  <= '0;
      active_flag  <= 1'b0;
      cursor_valid <= 1'b0;
      accepted     <= 1'b0;
      ovf          <= 1'b0;
      skipped      <= 9'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item     <= cmd;
            accepted <= 1'b0;
            ovf      <= 1'b0;
            skipped  <= 9'd0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_EMIT;
          unique case (item.func)
            tcs_pkg::FUNC_PUSH: begin
              if (full) begin
                ovf <= 1'b1;
              end else begin
                tail_index  <= advance(tail_index, cfg.capacity);
                entry_count <= entry_count + CNT_W'(1);
                accepted    <= 1'b1;
              end
            end
            tcs_pkg::FUNC_PACKET: ;
            tcs_pkg::FUNC_TICK: begin
              if (!link_up) begin
                head_index   <= '0;
                tail_index   <= '0;
                entry_count  <= '0;
                active_flag  <= 1'b0;
                cursor_valid <= 1'b0;
              end else begin
                if (expired) begin
                  time_cursor  <= expire_end_s[32:0];
                  cursor_valid <= 1'b1;
                  active_flag  <= 1'b0;
                end
                if (!active_flag || expired) begin
                  state <= S_PROM;
                end
              end
            end
            default: begin
              head_index   <= '0;
              tail_index   <= '0;
              entry_count  <= '0;
              active_flag  <= 1'b0;
              cursor_valid <= 1'b0;
            end
          endcase
        end
        S_PROM: begin
          // The read of the head slot is issued here when the queue holds entries.
          cursor_valid <= 1'b1;
          if (entry_count == '0) begin
            time_cursor <= (cursor_eff < now_ext) ? now_ext : cursor_eff;
            state       <= S_EMIT;
          end else begin
            time_cursor <= cursor_eff;
            state       <= S_EVAL;
          end
        end
        S_EVAL: begin
          head_index  <= advance(head_index, cfg.capacity);
          entry_count <= entry_count - CNT_W'(1);
          if (skip_entry) begin
            time_cursor <= end_s[32:0];
            skipped     <= skipped + 9'd1;
            state       <= (entry_count == CNT_W'(1)) ? S_EMIT : S_PROM;
          end else begin
            active_flag  <= 1'b1;
            active_pay   <= rd_pay;
            active_dur   <= rd_dur;
            active_start <= late ? floor_s[32:0] : time_cursor;
            time_cursor  <= late ? late_end_s[32:0] : end_s[32:0];
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result beat assembled from the state after the event.
  always_comb begin
    rsp_next.push_accepted      = accepted;
    rsp_next.overflow           = ovf;
    rsp_next.connected          = link_up;
    rsp_next.active_valid       = active_flag;
    rsp_next.active_payload     = active_flag ? 32'(active_pay) : 32'd0;
    rsp_next.active_duration_ms = active_flag ? active_dur : 16'd0;
    rsp_next.active_start_ms    = active_flag ? active_start : 33'd0;
    rsp_next.queue_count        = 9'(entry_count);
    rsp_next.skipped_count      = skipped;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_EMIT && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!rsp_valid || rsp_ready)) begin
      rsp <= rsp_next;
    end
  end

  // A slot is only checked while the queue holds at least one entry.
  a_eval_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (entry_count != '0))
    else $error("slot checked with an empty queue");

  // A stored push grows the queue by exactly one entry.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && item.func == tcs_pkg::FUNC_PUSH && !full)
    |=> (entry_count == $past(entry_count) + CNT_W'(1)))
    else $error("stored push did not grow the queue by one");

  // A clear empties the queue and drops the active command.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && item.func == tcs_pkg::FUNC_CLEAR)
    |=> (entry_count == '0 && !active_flag && !cursor_valid))
    else $error("clear left queue or active command behind");

  // An inactive result carries zero command fields.
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.active_valid)
    |-> (rsp.active_payload == 32'd0 && rsp.active_duration_ms == 16'd0
         && rsp.active_start_ms == 33'd0))
    else $error("inactive result carries command fields");

endmodule
